// ----- hw/rtl/otd_pkg.sv -----
// ----------------------------------------------------------------------------
// otd_pkg: shared types and constants of the per-target outage detector
// Holds the channel payload structs, the command format between the front and
// back parts, the table entry layout and the configuration register bundle.
// ----------------------------------------------------------------------------
package otd_pkg;

  // Operation codes of an input transaction.
  localparam logic [1:0] OP_PROBE    = 2'd0;
  localparam logic [1:0] OP_GAP      = 2'd1;
  localparam logic [1:0] OP_FINALIZE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_FAIL_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_MIN_OUTAGE_MS  = 2'd1;
  localparam logic [1:0] REG_TRIGGER_TRACE  = 2'd2;
  localparam logic [1:0] REG_TOTAL_TARGETS  = 2'd3;

  // Result kinds.
  localparam logic KIND_OPENED = 1'b0;
  localparam logic KIND_CLOSED = 1'b1;

  // Widespread test: more than WIDE_MIN_TARGETS targets and at least
  // WIDE_PCT percent of them failing.
  localparam int unsigned PCT_SCALE        = 100;
  localparam int unsigned WIDE_PCT         = 75;
  localparam int unsigned WIDE_MIN_TARGETS = 2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  tgt;
    logic [47:0] time_ms;
    logic        failed;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] event_number;
    logic [5:0]  report_target;
    logic [47:0] start_ms;
    logic [47:0] end_ms;
    logic [31:0] sent_count;
    logic [31:0] lost_count;
    logic        widespread;
    logic        trace_taken;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] fail_limit;
    logic [31:0] min_dur_ms;
    logic        trigger_trace;
    logic [6:0]  tgt_count;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_PROBE = 2'd0,
    CMD_GAP   = 2'd1,
    CMD_FIN   = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [5:0]  target;
    logic [47:0] time_ms;
    logic        failed;
  } cmd_t;

  // One row of the per-target table.
  typedef struct packed {
    logic [15:0] fail_run;
    logic [47:0] run_start;
    logic [47:0] outage_start;
    logic [31:0] sent;
    logic [31:0] lost;
    logic        wide;
    logic        trace;
    logic [47:0] last_seen;
  } entry_t;

endpackage

// ----- hw/rtl/otd_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// otd_cmd_queue: front part of the outage detector
// Accepts input transactions, drops those that do nothing and queues the rest
// as commands in a two-entry queue for the table engine.
// ----------------------------------------------------------------------------
module otd_cmd_queue #(
  parameter int unsigned TARGETS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  otd_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output otd_pkg::cmd_t     cmd
);

  otd_pkg::cmd_t q_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;
  logic          keep;
  logic          push;
  logic          pop;
  otd_pkg::cmd_t cls;

  // Classify: probes for targets outside the table and unknown codes vanish.
  always_comb begin
    cls.target  = in_data.tgt;
    cls.time_ms = in_data.time_ms;
    cls.failed  = in_data.failed;
    cls.op      = otd_pkg::CMD_PROBE;
    keep        = 1'b0;
    unique case (in_data.operation)
      otd_pkg::OP_PROBE: begin
        cls.op = otd_pkg::CMD_PROBE;
        keep   = 32'(in_data.tgt) < TARGETS;
      end
      otd_pkg::OP_GAP: begin
        cls.op = otd_pkg::CMD_GAP;
        keep   = 1'b1;
      end
      otd_pkg::OP_FINALIZE: begin
        cls.op = otd_pkg::CMD_FIN;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready  = cnt_r != 2'd2;
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && in_ready && keep;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hw/rtl/otd_engine.sv -----
// ----------------------------------------------------------------------------
// otd_engine: back part of the outage detector
// Owns the per-target table, runs probe read-modify-writes, gap clears and
// finalize sweeps, and delivers reports through a one-deep hold stage and an
// output register so the last flag is known before a report leaves.
// ----------------------------------------------------------------------------
module otd_engine #(
  parameter int unsigned TARGETS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  otd_pkg::cfg_t      cfg,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  otd_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output otd_pkg::out_item_t out_data
);

  localparam int unsigned IW = (TARGETS > 1) ? $clog2(TARGETS) : 1;
  localparam int unsigned CW = $clog2(TARGETS + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SWP   = 5'b00100,
    S_SWPEX = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  otd_pkg::cmd_t      cur_r, cur_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  otd_pkg::entry_t    mem [TARGETS];
  otd_pkg::entry_t    rdata_r;
  logic               rvld_r;
  logic [TARGETS-1:0] entry_vld_r, entry_vld_nxt;
  logic [TARGETS-1:0] outage_r, outage_nxt;
  logic [TARGETS-1:0] runnz_r, runnz_nxt;
  logic [CW-1:0]      fail_cnt_r, fail_cnt_nxt;
  logic [CW-1:0]      out_cnt_r, out_cnt_nxt;
  logic [31:0]        rpt_cnt_r, rpt_cnt_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  otd_pkg::out_item_t pend_r, pend_nxt;
  logic               out_vld_r, out_vld_nxt;
  otd_pkg::out_item_t out_r, out_nxt;

  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               mem_we;
  otd_pkg::entry_t    mem_wd;
  logic               out_free;

  otd_pkg::entry_t    d;
  otd_pkg::entry_t    nd;
  logic [IW-1:0]      t;
  logic [15:0]        fr;
  logic [15:0]        fr_inc;
  logic [47:0]        cand;
  logic [47:0]        endt;
  logic [47:0]        dur;
  logic               long_enough;
  logic [31:0]        nf;
  logic               wide;
  logic               new_out;
  logic               new_nz;
  logic               old_fb;
  logic               new_fb;
  logic               make;
  otd_pkg::out_item_t rpt;
  logic               last_idx;

  function automatic logic [31:0] sat32(input logic [31:0] v);
    sat32 = (v == '1) ? v : v + 32'd1;
  endfunction

  assign out_free  = !out_vld_r || out_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign cmd_ready = state_r == S_IDLE;
  assign t         = (state_r == S_EXEC) ? IW'(cur_r.target) : idx_r;
  assign d         = rvld_r ? rdata_r : '0;
  assign last_idx  = idx_r == IW'(TARGETS - 1);

  // Shared datapath for the entry under work.
  always_comb begin
    fr     = runnz_r[t] ? d.fail_run : 16'd0;
    fr_inc = (fr == 16'hFFFF) ? fr : fr + 16'd1;
    cand   = (fr == 16'd0) ? cur_r.time_ms : d.run_start;
    endt   = (state_r == S_EXEC || cur_r.time_ms > d.last_seen) ?
             cur_r.time_ms : d.last_seen;
    dur    = (endt > d.outage_start) ? endt - d.outage_start : 48'd0;
    long_enough = dur >= {16'd0, cfg.min_dur_ms};
    nf     = 32'(fail_cnt_r) + 32'(!runnz_r[t]);
    wide   = (32'(cfg.tgt_count) > otd_pkg::WIDE_MIN_TARGETS) &&
             (nf * otd_pkg::PCT_SCALE >= 32'(cfg.tgt_count) * otd_pkg::WIDE_PCT);
  end

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    idx_nxt       = idx_r;
    entry_vld_nxt = entry_vld_r;
    outage_nxt    = outage_r;
    runnz_nxt     = runnz_r;
    fail_cnt_nxt  = fail_cnt_r;
    out_cnt_nxt   = out_cnt_r;
    rpt_cnt_nxt   = rpt_cnt_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    out_vld_nxt   = out_ready ? 1'b0 : out_vld_r;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = t;
    mem_we        = 1'b0;
    nd            = d;
    new_out       = outage_r[t];
    new_nz        = runnz_r[t];
    make          = 1'b0;
    rpt           = '0;
    rpt.report_target = 6'(t);
    rpt.start_ms      = d.outage_start;
    rpt.widespread    = d.wide;
    rpt.trace_taken   = d.trace;
    rpt.sent_count    = d.sent;
    rpt.lost_count    = d.lost;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cur_nxt = cmd;
          unique case (cmd.op)
            otd_pkg::CMD_PROBE: begin
              rd_en     = 1'b1;
              rd_addr   = IW'(cmd.target);
              state_nxt = S_EXEC;
            end
            otd_pkg::CMD_GAP: begin
              runnz_nxt    = runnz_r & outage_r;
              fail_cnt_nxt = out_cnt_r;
            end
            otd_pkg::CMD_FIN: begin
              idx_nxt   = '0;
              state_nxt = S_SWP;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_EXEC: begin
        if (out_free) begin
          nd.last_seen = cur_r.time_ms;
          if (outage_r[t]) begin
            nd.sent = sat32(d.sent);
            if (cur_r.failed) begin
              nd.lost     = sat32(d.lost);
              nd.fail_run = fr_inc;
            end else begin
              new_out          = 1'b0;
              new_nz           = 1'b0;
              make             = long_enough;
              rpt.kind         = otd_pkg::KIND_CLOSED;
              rpt.event_number = rpt_cnt_r;
              rpt.end_ms       = cur_r.time_ms;
              rpt.sent_count   = nd.sent;
              if (long_enough) begin
                rpt_cnt_nxt = sat32(rpt_cnt_r);
              end
            end
          end else if (!cur_r.failed) begin
            new_nz      = 1'b0;
            nd.fail_run = 16'd0;
          end else begin
            nd.run_start = cand;
            nd.fail_run  = fr_inc;
            new_nz       = 1'b1;
            if (fr_inc >= cfg.fail_limit) begin
              new_out         = 1'b1;
              nd.outage_start = cand;
              nd.sent         = {16'd0, fr_inc};
              nd.lost         = {16'd0, fr_inc};
              nd.wide         = wide;
              nd.trace        = cfg.trigger_trace;
              make            = cfg.trigger_trace;
              rpt.kind        = otd_pkg::KIND_OPENED;
              rpt.start_ms    = cand;
              rpt.sent_count  = nd.sent;
              rpt.lost_count  = nd.lost;
              rpt.widespread  = wide;
              rpt.trace_taken = 1'b1;
            end
          end
          mem_we           = 1'b1;
          entry_vld_nxt[t] = 1'b1;
          state_nxt        = S_FLUSH;
        end
      end
      S_SWP: begin
        if (outage_r[idx_r]) begin
          rd_en     = 1'b1;
          state_nxt = S_SWPEX;
        end else if (last_idx) begin
          state_nxt = S_FLUSH;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      S_SWPEX: begin
        if (out_free) begin
          new_out          = 1'b0;
          new_nz           = 1'b0;
          make             = long_enough;
          rpt.kind         = otd_pkg::KIND_CLOSED;
          rpt.event_number = rpt_cnt_r;
          rpt.end_ms       = endt;
          if (long_enough) begin
            rpt_cnt_nxt = sat32(rpt_cnt_r);
          end
          if (last_idx) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            state_nxt = S_SWP;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_vld_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          out_vld_nxt   = 1'b1;
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
          pend_vld_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Table bits and the failing and outage counts follow the entry under work.
    if ((state_r == S_EXEC || state_r == S_SWPEX) && out_free) begin
      old_fb        = outage_r[t] | runnz_r[t];
      new_fb        = new_out | new_nz;
      outage_nxt[t] = new_out;
      runnz_nxt[t]  = new_nz;
      fail_cnt_nxt  = fail_cnt_r + CW'(new_fb) - CW'(old_fb);
      out_cnt_nxt   = out_cnt_r + CW'(new_out) - CW'(outage_r[t]);
    end else begin
      old_fb = 1'b0;
      new_fb = 1'b0;
    end

    // A new report pushes the held one out; it cannot be the last one.
    if (make) begin
      if (pend_vld_r) begin
        out_vld_nxt  = 1'b1;
        out_nxt      = pend_r;
        out_nxt.last = 1'b0;
      end
      pend_vld_nxt = 1'b1;
      pend_nxt     = rpt;
    end
    mem_wd = nd;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[t] <= mem_wd;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    cur_r  <= cur_nxt;
    idx_r  <= idx_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rvld_r      <= 1'b0;
      entry_vld_r <= '0;
      outage_r    <= '0;
      runnz_r     <= '0;
      fail_cnt_r  <= '0;
      out_cnt_r   <= '0;
      rpt_cnt_r   <= '0;
      pend_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (rd_en) begin
        rvld_r <= entry_vld_r[rd_addr];
      end
      entry_vld_r <= entry_vld_nxt;
      outage_r    <= outage_nxt;
      runnz_r     <= runnz_nxt;
      fail_cnt_r  <= fail_cnt_nxt;
      out_cnt_r   <= out_cnt_nxt;
      rpt_cnt_r   <= rpt_cnt_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // Nothing may be held back once an item is fully done.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_vld_r)
    else $error("held report left behind after a transaction");

  // Every target in an outage also counts as failing.
  a_cnt_order: assert property (@(posedge clk) disable iff (!rst_n)
    fail_cnt_r >= out_cnt_r)
    else $error("failing count below outage count");

  // A gap leaves no fail run outside an outage.
  a_gap_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && cmd_valid && cmd.op == otd_pkg::CMD_GAP)
    |=> ((runnz_r & ~outage_r) == '0))
    else $error("gap left a candidate run");

  // A stalled result is never overwritten.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |=> (out_vld_r && $stable(out_r)))
    else $error("result register overwritten while stalled");

endmodule

// ----- hw/rtl/per_target_outage_detector.sv -----
// ----------------------------------------------------------------------------
// per_target_outage_detector: per-target probe outage detector
// Tracks probe outcomes per target, opens and closes outages and reports them.
// ----------------------------------------------------------------------------
// A probe sample occupies the engine from the step that takes the command and
// reads the target's table row, through the step that updates the row and
// writes it back, to the step that releases the held report with its last
// flag; the registered table read and the release stage set this sequence, and
// the next command is taken after the release step. A gap transaction is
// handled entirely in the step that takes it. A finalize transaction is taken,
// then the whole table is swept: a target not in an outage is passed over, a
// target in one is read and then closed, and a last step releases the final
// report. The front queue holds two commands, so the input side can accept
// them while the engine is busy. A result that waits in the output register
// holds the engine at its next update, close or release step, so a long stall
// on the result side fills the front queue and then blocks the input.
// The table needs no clearing pass after reset: a valid bit per row makes an
// unwritten row read as zero.
module per_target_outage_detector #(
  parameter int unsigned TARGETS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  otd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output otd_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata
);

  otd_pkg::cfg_t cfg_r;
  logic          cmd_valid;
  logic          cmd_ready;
  otd_pkg::cmd_t cmd;

  // Config regs; user writes arrive only while idle; the block never checks.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fail_limit    <= 16'd3;
      cfg_r.min_dur_ms    <= 32'd0;
      cfg_r.trigger_trace <= 1'b0;
      cfg_r.tgt_count     <= 7'd0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        otd_pkg::REG_FAIL_THRESHOLD: cfg_r.fail_limit    <= cfg_wdata[15:0];
        otd_pkg::REG_MIN_OUTAGE_MS:  cfg_r.min_dur_ms    <= cfg_wdata;
        otd_pkg::REG_TRIGGER_TRACE:  cfg_r.trigger_trace <= cfg_wdata[0];
        otd_pkg::REG_TOTAL_TARGETS:  cfg_r.tgt_count     <= cfg_wdata[6:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  // Front part: accepts each transaction, drops the ones without effect.
  otd_cmd_queue #(
    .TARGETS(TARGETS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  // Back part: the table engine and the result path.
  otd_engine #(
    .TARGETS(TARGETS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the per-target outage detector
// Drives probe, gap and finalize transactions with random gaps on both sides.
// A behavioral copy of the outage table predicts every report, and each
// report that comes out is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NT = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;
  // Operation code without a meaning; the block must ignore it.
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  otd_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  otd_pkg::out_item_t out_data;
  logic               cfg_we;
  logic [1:0]         cfg_addr;
  logic [31:0]        cfg_wdata;

  per_target_outage_detector #(.TARGETS(NT)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the configuration registers.
  logic [15:0] thr_q;
  logic [31:0] min_dur_q;
  logic        trace_en_q;
  logic [6:0]  total_q;

  // Shadow copy of the per-target table.
  logic        sh_open    [NT];
  logic [15:0] sh_run     [NT];
  logic [47:0] sh_cand    [NT];
  logic [47:0] sh_start   [NT];
  logic [31:0] sh_sent    [NT];
  logic [31:0] sh_lost    [NT];
  logic        sh_wide    [NT];
  logic        sh_trace   [NT];
  logic [47:0] sh_seen    [NT];
  logic [31:0] close_seq;

  otd_pkg::out_item_t pending_reports[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  int  out_hold_cnt = 0;
  bit  out_stall_on = 1'b1;

  function automatic logic [31:0] sat32(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic otd_pkg::out_item_t make_report(logic k, logic [31:0] num, int t,
                                                     logic [47:0] endt);
    otd_pkg::out_item_t r;
    r.kind = k;
    r.event_number = num;
    r.report_target = t[5:0];
    r.start_ms = sh_start[t];
    r.end_ms = endt;
    r.sent_count = sh_sent[t];
    r.lost_count = sh_lost[t];
    r.widespread = sh_wide[t];
    r.trace_taken = sh_trace[t];
    r.last = 1'b0;
    return r;
  endfunction

  // Closes an outage in the shadow table and queues its report when the
  // outage lasted long enough. An end before the start counts as zero length.
  task automatic shadow_close(int t, logic [47:0] endt, inout otd_pkg::out_item_t res[$]);
    logic [47:0] dur;
    dur = (endt > sh_start[t]) ? endt - sh_start[t] : 48'd0;
    if (dur >= {16'd0, min_dur_q}) begin
      res.push_back(make_report(otd_pkg::KIND_CLOSED, close_seq, t, endt));
      close_seq = sat32(close_seq);
    end
    sh_open[t] = 1'b0;
    sh_run[t] = '0;
    sh_sent[t] = '0;
    sh_lost[t] = '0;
    sh_wide[t] = 1'b0;
    sh_trace[t] = 1'b0;
  endtask

  // Applies one accepted transaction to the shadow table and appends the
  // reports it causes to the queue of pending reports.
  task automatic predict_reports(otd_pkg::in_item_t it);
    otd_pkg::out_item_t res[$];
    int t;
    int nf;
    logic [47:0] e;
    t = it.tgt;
    case (it.operation)
      otd_pkg::OP_PROBE: begin
        sh_seen[t] = it.time_ms;
        if (sh_open[t]) begin
          sh_sent[t] = sat32(sh_sent[t]);
          if (it.failed) begin
            sh_lost[t] = sat32(sh_lost[t]);
            if (sh_run[t] != 16'hFFFF) sh_run[t]++;
          end else begin
            shadow_close(t, it.time_ms, res);
          end
        end else if (!it.failed) begin
          sh_run[t] = '0;
        end else begin
          if (sh_run[t] == 0) sh_cand[t] = it.time_ms;
          if (sh_run[t] != 16'hFFFF) sh_run[t]++;
          if (sh_run[t] >= thr_q) begin
            sh_open[t] = 1'b1;
            sh_start[t] = sh_cand[t];
            sh_sent[t] = {16'd0, sh_run[t]};
            sh_lost[t] = {16'd0, sh_run[t]};
            nf = 0;
            for (int i = 0; i < NT; i++) if (sh_open[i] || sh_run[i] != 0) nf++;
            sh_wide[t] = (total_q > otd_pkg::WIDE_MIN_TARGETS) &&
                         (nf * otd_pkg::PCT_SCALE >= total_q * otd_pkg::WIDE_PCT);
            sh_trace[t] = trace_en_q;
            if (trace_en_q) begin
              res.push_back(make_report(otd_pkg::KIND_OPENED, '0, t, '0));
            end
          end
        end
      end
      otd_pkg::OP_GAP: begin
        for (int i = 0; i < NT; i++) if (!sh_open[i]) sh_run[i] = '0;
      end
      otd_pkg::OP_FINALIZE: begin
        for (int i = 0; i < NT; i++) begin
          if (sh_open[i]) begin
            e = (it.time_ms > sh_seen[i]) ? it.time_ms : sh_seen[i];
            shadow_close(i, e, res);
          end
        end
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_reports.push_back(res[i]);
  endtask

  // Short gaps are common, long ones are rare, and some runs have none.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sends one transaction: valid rises at a clock edge and holds until the
  // transaction is taken, then the prediction is made. Valid stays high into
  // the next transaction when there is no gap; the caller that idles the
  // input afterwards drops it.
  task automatic send_item(logic [1:0] op, int t, logic [47:0] tm, logic f);
    otd_pkg::in_item_t it;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    it.operation = op;
    it.tgt = t[5:0];
    it.time_ms = tm;
    it.failed = f;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_reports(it);
  endtask

  // Writes a register while the block is idle; the shadow copy follows.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      otd_pkg::REG_FAIL_THRESHOLD: thr_q = val[15:0];
      otd_pkg::REG_MIN_OUTAGE_MS:  min_dur_q = val;
      otd_pkg::REG_TRIGGER_TRACE:  trace_en_q = val[0];
      otd_pkg::REG_TOTAL_TARGETS:  total_q = val[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Waits until every predicted report has come out, then waits out the
  // drain period so that nothing is still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Output side: random backpressure and the comparison of each report.
  always @(posedge clk) begin
    otd_pkg::out_item_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_reports.size() == 0) begin
          $error("unexpected report for target %0d", out_data.report_target);
          error_count++;
        end else begin
          exp_r = pending_reports.pop_front();
          if (out_data.kind !== exp_r.kind) begin
            $error("kind: expected %0h actual %0h", exp_r.kind, out_data.kind);
            error_count++;
          end
          if (out_data.event_number !== exp_r.event_number) begin
            $error("event_number: expected %0h actual %0h",
                   exp_r.event_number, out_data.event_number);
            error_count++;
          end
          if (out_data.report_target !== exp_r.report_target) begin
            $error("report_target: expected %0h actual %0h",
                   exp_r.report_target, out_data.report_target);
            error_count++;
          end
          if (out_data.start_ms !== exp_r.start_ms) begin
            $error("start_ms: expected %0h actual %0h", exp_r.start_ms, out_data.start_ms);
            error_count++;
          end
          if (out_data.end_ms !== exp_r.end_ms) begin
            $error("end_ms: expected %0h actual %0h", exp_r.end_ms, out_data.end_ms);
            error_count++;
          end
          if (out_data.sent_count !== exp_r.sent_count) begin
            $error("sent_count: expected %0h actual %0h",
                   exp_r.sent_count, out_data.sent_count);
            error_count++;
          end
          if (out_data.lost_count !== exp_r.lost_count) begin
            $error("lost_count: expected %0h actual %0h",
                   exp_r.lost_count, out_data.lost_count);
            error_count++;
          end
          if (out_data.widespread !== exp_r.widespread) begin
            $error("widespread: expected %0h actual %0h",
                   exp_r.widespread, out_data.widespread);
            error_count++;
          end
          if (out_data.trace_taken !== exp_r.trace_taken) begin
            $error("trace_taken: expected %0h actual %0h",
                   exp_r.trace_taken, out_data.trace_taken);
            error_count++;
          end
          if (out_data.last !== exp_r.last) begin
            $error("last: expected %0h actual %0h", exp_r.last, out_data.last);
            error_count++;
          end
        end
      end
      // Stalls are mostly short with a few long ones; a phase may switch
      // them off entirely.
      if (out_hold_cnt > 0) begin
        out_ready <= 1'b0;
        out_hold_cnt <= out_hold_cnt - 1;
      end else if (out_stall_on && $urandom_range(0, 99) < 30) begin
        out_ready <= 1'b0;
        out_hold_cnt <= gap_len();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any accepted transaction on either side, a register write or reset restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT + DRAIN_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Random 48-bit time, sometimes near the top of the range.
  function automatic logic [47:0] rand_time();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  // Directed part: field extremes, every operation, odd cases.
  task automatic test_directed();
    write_reg(otd_pkg::REG_FAIL_THRESHOLD, 32'd2);
    write_reg(otd_pkg::REG_MIN_OUTAGE_MS, 32'd0);
    write_reg(otd_pkg::REG_TRIGGER_TRACE, 32'd1);
    write_reg(otd_pkg::REG_TOTAL_TARGETS, 32'd3);
    // Two failures open an outage on target 0; a success closes it.
    send_item(otd_pkg::OP_PROBE, 0, 48'd100, 1'b1);
    send_item(otd_pkg::OP_PROBE, 0, 48'd200, 1'b1);
    send_item(otd_pkg::OP_PROBE, 0, 48'd300, 1'b1);
    send_item(otd_pkg::OP_PROBE, 0, 48'd400, 1'b0);
    // Highest target and time; the close comes before the start.
    send_item(otd_pkg::OP_PROBE, 63, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_item(otd_pkg::OP_PROBE, 63, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_item(otd_pkg::OP_PROBE, 63, 48'd5, 1'b0);
    // Gap clears a run; the unknown operation is ignored.
    send_item(otd_pkg::OP_PROBE, 7, 48'd10, 1'b1);
    send_item(otd_pkg::OP_GAP, 0, 48'd0, 1'b0);
    send_item(OP_UNKNOWN, 42, 48'h5555_5555_5555, 1'b1);
    send_item(otd_pkg::OP_PROBE, 7, 48'd20, 1'b1);
    // Widespread opening with three targets failing.
    send_item(otd_pkg::OP_PROBE, 1, 48'd50, 1'b1);
    send_item(otd_pkg::OP_PROBE, 2, 48'd51, 1'b1);
    send_item(otd_pkg::OP_PROBE, 1, 48'd52, 1'b1);
    send_item(otd_pkg::OP_PROBE, 2, 48'd53, 1'b1);
    // Finalize with a time before some last samples.
    send_item(otd_pkg::OP_FINALIZE, 21, 48'd52, 1'b0);
    send_item(otd_pkg::OP_FINALIZE, 0, 48'd60, 1'b1);
    wait_idle();
    // Zero threshold and a large minimum duration that suppresses a close.
    write_reg(otd_pkg::REG_FAIL_THRESHOLD, 32'd0);
    write_reg(otd_pkg::REG_MIN_OUTAGE_MS, 32'hFFFF_FFFF);
    write_reg(otd_pkg::REG_TRIGGER_TRACE, 32'd0);
    write_reg(otd_pkg::REG_TOTAL_TARGETS, 32'd64);
    send_item(otd_pkg::OP_PROBE, 9, 48'd1000, 1'b1);
    send_item(otd_pkg::OP_PROBE, 9, 48'd1001, 1'b0);
    send_item(otd_pkg::OP_PROBE, 10, 48'hAAAA_AAAA_AAAA, 1'b1);
    send_item(otd_pkg::OP_FINALIZE, 0, 48'hFFFF_FFFF_FFFF, 1'b0);
    wait_idle();
  endtask

  // Random part: runs of failures on a few hot targets with occasional gap
  // and finalize transactions and some noise on any target.
  task automatic test_random(int n_items, logic [15:0] thr, logic [31:0] mind,
                             logic trig, logic [6:0] tot);
    logic [47:0] clock_ms;
    int t;
    int r;
    write_reg(otd_pkg::REG_FAIL_THRESHOLD, {16'd0, thr});
    write_reg(otd_pkg::REG_MIN_OUTAGE_MS, mind);
    write_reg(otd_pkg::REG_TRIGGER_TRACE, {31'd0, trig});
    write_reg(otd_pkg::REG_TOTAL_TARGETS, {25'd0, tot});
    clock_ms = rand_time() >> $urandom_range(0, 47);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      clock_ms = clock_ms + 48'($urandom_range(0, 300));
      if (r < 3) begin
        send_item(otd_pkg::OP_GAP, $urandom_range(0, 63), rand_time(),
                  1'($urandom_range(0, 1)));
      end else if (r < 6) begin
        send_item(otd_pkg::OP_FINALIZE, $urandom_range(0, 63), clock_ms,
                  1'($urandom_range(0, 1)));
      end else if (r < 8) begin
        send_item(otd_pkg::OP_PROBE, $urandom_range(0, 63), rand_time(),
                  1'($urandom_range(0, 1)));
      end else begin
        t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
        send_item(otd_pkg::OP_PROBE, t, clock_ms, $urandom_range(0, 99) < 65);
      end
    end
    send_item(otd_pkg::OP_FINALIZE, 0, clock_ms, 1'b0);
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    thr_q = 16'd3;
    min_dur_q = '0;
    trace_en_q = 1'b0;
    total_q = '0;
    close_seq = '0;
    for (int i = 0; i < NT; i++) begin
      sh_open[i] = 0; sh_run[i] = 0; sh_cand[i] = 0; sh_start[i] = 0;
      sh_sent[i] = 0; sh_lost[i] = 0; sh_wide[i] = 0; sh_trace[i] = 0;
      sh_seen[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(80, 16'd1, 32'd0, 1'b1, 7'd4);
    test_random(80, 16'd3, 32'd200, 1'b0, 7'd8);
    out_stall_on = 1'b0;
    test_random(80, 16'd2, 32'd50, 1'b1, 7'd3);
    out_stall_on = 1'b1;
    test_random(60, 16'hFFFF, 32'd0, 1'b1, 7'd2);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/otd_pkg.sv
hw/rtl/otd_cmd_queue.sv
hw/rtl/otd_engine.sv
hw/rtl/per_target_outage_detector.sv
tb/sv/tb_top.sv
